/* design/longest_increasing_subsequence_defines.svh */
// assertion macros used by longest_increasing_subsequence.sv
`ifndef LONGEST_INCREASING_SUBSEQUENCE_DEFINES_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_DEFINES_SVH

`ifndef SYNTHESIS

// property checked every clock, skipped while reset is high
`define LIS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked every clock, reset included
`define LIS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LIS_ASSERT(label, clk, rst, prop, msg)
`define LIS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* design/lis_pkg.sv */
`default_nettype none

package lis_pkg;

   // default capacity and stored value width
   localparam int MAX_ITEMS_DEFAULT  = 64;
   localparam int VALUE_BITS_DEFAULT = 32;

   // fixed field widths of the channels
   localparam int SAMPLE_W = 32;
   localparam int POS_W    = 6;
   localparam int LEN_W    = 7;

   // request operation codes
   localparam logic OP_PUSH   = 1'b0;
   localparam logic OP_REPORT = 1'b1;

endpackage

`default_nettype wire

/* design/longest_increasing_subsequence.sv */
// Longest increasing subsequence, patience-sort form. A push beat (op 0)
// places its value by binary search in a tail memory holding the smallest
// tail value of each subsequence length, and records the element with a
// back pointer in an element memory. The search takes at most
// ceil(log2(length + 1)) steps, one tail memory read per step; a push that
// is kept always finds at most 63 lengths with 64 entries, and a push to an
// empty table skips the search. A push beyond MAX_ITEMS values is dropped
// and sets the overflow flag. A report beat (op 1) walks the back pointers
// through the element memory, one element memory read per result, and
// returns the members from last to first, then clears the block. An empty
// sequence gives one result of length 0. The result register lets the block
// take new pushes while a result still waits. non_decreasing_mode (the bit
// written by csr_wr_en) chooses between strict and non-decreasing order; the
// user must write it only while the block is idle, as the block itself does
// not enforce this.
`default_nettype none

module longest_increasing_subsequence #(
   parameter int MAX_ITEMS  = lis_pkg::MAX_ITEMS_DEFAULT,
   parameter int VALUE_BITS = lis_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic                                csr_wr_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_op,
   input  wire logic signed [lis_pkg::SAMPLE_W-1:0] req_sample_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed      [lis_pkg::SAMPLE_W-1:0] rsp_element_value,
   output logic             [lis_pkg::POS_W-1:0]    rsp_element_position,
   output logic             [lis_pkg::LEN_W-1:0]    rsp_subsequence_length,
   output logic                                     rsp_overflowed,
   output logic                                     rsp_last
);

   `include "longest_increasing_subsequence_defines.svh"

   localparam int SAMPLE_W = lis_pkg::SAMPLE_W;
   localparam int POS_W    = lis_pkg::POS_W;
   localparam int LEN_W    = lis_pkg::LEN_W;
   localparam int IDX_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W    = IDX_W + 1;
   localparam int ENTRY_W  = VALUE_BITS + IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WRITE,
      ST_REP_IDX,
      ST_REP_ELEM,
      ST_EMPTY
   } state_type;

   state_type                     state_ff, state_in;
   logic                          mode_ff, mode_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              best_ff, best_in;
   logic                          ovf_ff, ovf_in;
   logic [CNT_W-1:0]              lo_ff, lo_in;
   logic [CNT_W-1:0]              hi_ff, hi_in;
   logic [IDX_W-1:0]              mid_ff, mid_in;
   logic [IDX_W-1:0]              k_ff, k_in;
   logic signed [VALUE_BITS-1:0]  sample_ff, sample_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]              rsp_pos_ff, rsp_pos_in;
   logic [LEN_W-1:0]              rsp_len_ff, rsp_len_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          tail_wr_en, tail_rd_en;
   logic [IDX_W-1:0]              tail_wr_addr, tail_rd_addr;
   logic [ENTRY_W-1:0]            tail_wr_data, tail_rd_data;
   logic                          elem_wr_en, elem_rd_en;
   logic [IDX_W-1:0]              elem_wr_addr, elem_rd_addr;
   logic [ENTRY_W-1:0]            elem_wr_data, elem_rd_data;

   logic signed [VALUE_BITS-1:0]  tail_rd_value, elem_rd_value;
   logic [IDX_W-1:0]              tail_rd_index, elem_rd_bp;
   logic signed [VALUE_BITS-1:0]  req_value;
   logic                          req_accept, slot_free, go_right;
   logic [CNT_W-1:0]              lo_next, hi_next, best_minus1;
   logic [CNT_W:0]                mid_sum;

   // tail memory: smallest tail value and its element index per length
   lis_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ITEMS),
      .AW    (IDX_W)
   ) u_tail_ram (
      .clock   (clock),
      .wr_en   (tail_wr_en),
      .wr_addr (tail_wr_addr),
      .wr_data (tail_wr_data),
      .rd_en   (tail_rd_en),
      .rd_addr (tail_rd_addr),
      .rd_data (tail_rd_data)
   );

   // element memory: value and back pointer per pushed element
   lis_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ITEMS),
      .AW    (IDX_W)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (elem_wr_data),
      .rd_en   (elem_rd_en),
      .rd_addr (elem_rd_addr),
      .rd_data (elem_rd_data)
   );

   assign tail_rd_value = tail_rd_data[ENTRY_W-1:IDX_W];
   assign tail_rd_index = tail_rd_data[IDX_W-1:0];
   assign elem_rd_value = elem_rd_data[ENTRY_W-1:IDX_W];
   assign elem_rd_bp    = elem_rd_data[IDX_W-1:0];

   // handshake and common terms
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign req_value   = VALUE_BITS'(req_sample_value);
   assign best_minus1 = best_ff - CNT_W'(1);

   // one search step: compare the tail read at mid and narrow the range
   assign go_right = mode_ff ? (tail_rd_value <= sample_ff) : (tail_rd_value < sample_ff);
   assign lo_next  = go_right ? (CNT_W'(mid_ff) + CNT_W'(1)) : lo_ff;
   assign hi_next  = go_right ? hi_ff : CNT_W'(mid_ff);
   assign mid_sum  = {1'b0, lo_next} + {1'b0, hi_next};

   // memory writes of a push
   assign tail_wr_en   = (state_ff == ST_WRITE);
   assign tail_wr_addr = lo_ff[IDX_W-1:0];
   assign tail_wr_data = {sample_ff, count_ff[IDX_W-1:0]};
   assign elem_wr_en   = (state_ff == ST_WRITE);
   assign elem_wr_addr = count_ff[IDX_W-1:0];
   assign elem_wr_data = {sample_ff, tail_rd_index};

   // next state, counters, reads and result register
   always_comb begin
      state_in     = state_ff;
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      count_in     = count_ff;
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      k_in         = k_ff;
      sample_in    = sample_ff;
      tail_rd_en   = 1'b0;
      tail_rd_addr = mid_ff;
      elem_rd_en   = 1'b0;
      elem_rd_addr = elem_rd_bp;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_op == lis_pkg::OP_PUSH) begin
               if (count_ff == CNT_W'(MAX_ITEMS)) begin
                  ovf_in = 1'b1;
               end else begin
                  sample_in = req_value;
                  lo_in     = '0;
                  hi_in     = best_ff;
                  mid_in    = best_ff[IDX_W:1];
                  if (best_ff != '0) begin
                     tail_rd_en   = 1'b1;
                     tail_rd_addr = best_ff[IDX_W:1];
                     state_in     = ST_SEARCH;
                  end else begin
                     state_in = ST_WRITE;
                  end
               end
            end else if (req_accept) begin
               if (best_ff == '0) begin
                  state_in = ST_EMPTY;
               end else begin
                  tail_rd_en   = 1'b1;
                  tail_rd_addr = best_minus1[IDX_W-1:0];
                  k_in         = best_minus1[IDX_W-1:0];
                  state_in     = ST_REP_IDX;
               end
            end
         end

         ST_SEARCH: begin
            lo_in  = lo_next;
            hi_in  = hi_next;
            mid_in = mid_sum[IDX_W:1];
            if (lo_next < hi_next) begin
               tail_rd_en   = 1'b1;
               tail_rd_addr = mid_sum[IDX_W:1];
            end else begin
               // fetch the predecessor's index from the length below
               tail_rd_en   = (lo_next != '0);
               tail_rd_addr = IDX_W'(lo_next - CNT_W'(1));
               state_in     = ST_WRITE;
            end
         end

         ST_WRITE: begin
            count_in = count_ff + CNT_W'(1);
            if (lo_ff == best_ff) begin
               best_in = best_ff + CNT_W'(1);
            end
            state_in = ST_IDLE;
         end

         ST_REP_IDX: begin
            elem_rd_en   = 1'b1;
            elem_rd_addr = tail_rd_index;
            state_in     = ST_REP_ELEM;
         end

         ST_REP_ELEM: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = SAMPLE_W'(elem_rd_value);
               rsp_pos_in   = POS_W'(k_ff);
               rsp_len_in   = LEN_W'(best_ff);
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = (k_ff == '0);
               if (k_ff == '0) begin
                  count_in = '0;
                  best_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  elem_rd_en   = 1'b1;
                  elem_rd_addr = elem_rd_bp;
                  k_in         = k_ff - IDX_W'(1);
               end
            end
         end

         ST_EMPTY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_pos_in   = '0;
               rsp_len_in   = '0;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = 1'b1;
               count_in     = '0;
               best_in      = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         count_ff     <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      k_ff         <= k_in;
      sample_ff    <= sample_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_element_value      = rsp_value_ff;
   assign rsp_element_position   = rsp_pos_ff;
   assign rsp_subsequence_length = rsp_len_ff;
   assign rsp_overflowed         = rsp_ovf_ff;
   assign rsp_last               = rsp_last_ff;

   // checks
   `LIS_ASSERT(a_best_le_count, clock, reset, best_ff <= count_ff,
               "length exceeds element count")
   `LIS_ASSERT(a_count_in_range, clock, reset, count_ff <= CNT_W'(MAX_ITEMS),
               "element count exceeds capacity")
   `LIS_ASSERT(a_search_range, clock, reset,
               (state_ff == ST_SEARCH) |-> (lo_ff < hi_ff && hi_ff <= best_ff),
               "search range out of order")
   `LIS_ASSERT(a_write_room, clock, reset,
               (state_ff == ST_WRITE) |-> (count_ff < CNT_W'(MAX_ITEMS) && lo_ff <= best_ff),
               "push written without room")
   `LIS_ASSERT(a_report_clears, clock, reset,
               (state_ff == ST_REP_ELEM && slot_free && k_ff == '0)
                  |=> (count_ff == '0 && best_ff == '0 && !ovf_ff),
               "report did not clear the block")

endmodule

`default_nettype wire

/* design/lis_ram.sv */
`default_nettype none

module lis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds its data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* tb/tb_longest_increasing_subsequence.sv */
`default_nettype none

module tb_longest_increasing_subsequence;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          SAMPLE_W = lis_pkg::SAMPLE_W;
   localparam int          POS_W    = lis_pkg::POS_W;
   localparam int          LEN_W    = lis_pkg::LEN_W;
   localparam int unsigned CAPACITY = lis_pkg::MAX_ITEMS_DEFAULT;
   localparam logic [6:0]  NO_LINK  = 7'd127;

   // one result beat, field by field
   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic [POS_W-1:0]    position;
      logic [LEN_W-1:0]    length;
      logic                overflowed;
      logic                last;
   } member_beat_type;

   localparam member_beat_type NO_RESULT = '0;

   typedef enum logic [1:0] {ROW_PUSH, ROW_REPORT, ROW_MODE} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [SAMPLE_W-1:0] value;
      logic                typed;
      member_beat_type     want;
   } script_row_type;

   typedef enum logic [1:0] {STYLE_WIDE, STYLE_NARROW, STYLE_EDGE, STYLE_DRIFT} value_style_type;

   // directed rows; typed expectations only where obvious
   localparam int unsigned ROWS = 27;
   localparam script_row_type SCRIPT [ROWS] = '{
      '{ROW_REPORT, 32'h0000_0000, 1'b1, '{32'h0000_0000, 6'd0, 7'd0, 1'b0, 1'b1}},
      '{ROW_MODE,   32'h0000_0000, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'h8000_0000, 1'b0, NO_RESULT},
      '{ROW_REPORT, 32'hffff_ffff, 1'b1, '{32'h8000_0000, 6'd0, 7'd1, 1'b0, 1'b1}},
      '{ROW_PUSH,   32'h7fff_ffff, 1'b0, NO_RESULT},
      '{ROW_REPORT, 32'h5555_aaaa, 1'b1, '{32'h7fff_ffff, 6'd0, 7'd1, 1'b0, 1'b1}},
      '{ROW_PUSH,   32'h0000_0003, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'h0000_0003, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'h0000_0003, 1'b0, NO_RESULT},
      '{ROW_REPORT, 32'haaaa_5555, 1'b0, NO_RESULT},
      '{ROW_MODE,   32'h0000_0001, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'h0000_0003, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'h0000_0003, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'h0000_0003, 1'b0, NO_RESULT},
      '{ROW_REPORT, 32'h0000_0000, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'hffff_ffff, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'h0000_0000, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'hffff_ffff, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'h7fff_ffff, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'h8000_0000, 1'b0, NO_RESULT},
      '{ROW_REPORT, 32'h0000_0000, 1'b0, NO_RESULT},
      '{ROW_MODE,   32'h0000_0000, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'h0000_0005, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'h0000_0005, 1'b0, NO_RESULT},
      '{ROW_MODE,   32'h0000_0001, 1'b0, NO_RESULT},
      '{ROW_PUSH,   32'h0000_0005, 1'b0, NO_RESULT},
      '{ROW_REPORT, 32'h0000_0000, 1'b0, NO_RESULT}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic                       csr_wr_data = 1'b0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_op = lis_pkg::OP_PUSH;
   logic signed [SAMPLE_W-1:0] req_sample_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_element_value;
   logic        [POS_W-1:0]    rsp_element_position;
   logic        [LEN_W-1:0]    rsp_subsequence_length;
   logic                       rsp_overflowed;
   logic                       rsp_last;

   // predictor copy of the block state
   logic signed [SAMPLE_W-1:0] kept_value [CAPACITY];
   logic        [6:0]          kept_link  [CAPACITY];
   logic        [POS_W-1:0]    tail_at    [CAPACITY];
   logic signed [SAMPLE_W-1:0] tail_min   [CAPACITY];
   int unsigned                kept_count = 0;
   int unsigned                chain_best = 0;
   bit                         dropped    = 1'b0;
   bit                         mode_nd    = 1'b0;

   member_beat_type expected_members [$];
   int unsigned     mismatches    = 0;
   int unsigned     beats_sent    = 0;
   int unsigned     results_seen  = 0;
   bit              sender_steady = 1'b0;
   bit              hold_asked    = 1'b0;

   longest_increasing_subsequence dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_op                (req_op),
      .req_sample_value      (req_sample_value),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_element_value     (rsp_element_value),
      .rsp_element_position  (rsp_element_position),
      .rsp_subsequence_length(rsp_subsequence_length),
      .rsp_overflowed        (rsp_overflowed),
      .rsp_last              (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** longest_increasing_subsequence: FAILED **");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   // patience placement of a pushed value, or the walk back for a report
   function automatic void lis_predict(input logic op, input logic signed [SAMPLE_W-1:0] v,
                                       ref member_beat_type due [$]);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned k;
      logic [6:0]  at;
      bit          go_right;
      lo = 0;
      hi = chain_best;
      if (op == lis_pkg::OP_PUSH) begin
         // full table: value dropped and flagged
         if (kept_count >= CAPACITY) begin
            dropped = 1'b1;
            return;
         end
         // lower bound for strict, upper bound for non-decreasing
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            go_right = mode_nd ? (tail_min[mid] <= v) : (tail_min[mid] < v);
            if (go_right) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         kept_link[kept_count] = (lo > 0) ? 7'(tail_at[lo-1]) : NO_LINK;
         tail_at[lo]  = POS_W'(kept_count);
         tail_min[lo] = v;
         kept_value[kept_count] = v;
         if (lo == chain_best) begin
            chain_best++;
         end
         kept_count++;
         return;
      end
      // empty sequence reports a single zero-length beat
      if (chain_best == 0) begin
         due.insert(due.size(), member_beat_type'{'0, '0, '0, dropped, 1'b1});
      end else begin
         at = 7'(tail_at[chain_best-1]);
         k  = chain_best;
         while (k > 0) begin
            k--;
            due.insert(due.size(),
                       member_beat_type'{kept_value[at[POS_W-1:0]], POS_W'(k),
                                         LEN_W'(chain_best), dropped, (k == 0)});
            at = kept_link[at[POS_W-1:0]];
         end
      end
      kept_count = 0;
      chain_best = 0;
      dropped    = 1'b0;
   endfunction

   // offer one beat, predict on acceptance, then sometimes idle a while
   task automatic send_beat(input logic op, input logic [SAMPLE_W-1:0] v, input bit typed,
                            input member_beat_type want);
      member_beat_type fresh [$];
      int unsigned     r;
      int unsigned     gap;
      req_valid        <= 1'b1;
      req_op           <= op;
      req_sample_value <= v;
      do @(posedge clock); while (req_stall !== 1'b0);
      lis_predict(op, v, fresh);
      if (typed) begin
         fresh = '{want};
      end
      foreach (fresh[i]) begin
         expected_members.insert(expected_members.size(), fresh[i]);
      end
      beats_sent++;
      r = $urandom_range(0, 99);
      if (sender_steady || r < 55) begin
         gap = 0;
      end else if (r < 85) begin
         gap = $urandom_range(1, 3);
      end else if (r < 97) begin
         gap = $urandom_range(4, 10);
      end else begin
         gap = $urandom_range(20, 50);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // mode write once the block has drained and any push has settled
   task automatic set_mode(input bit m);
      req_valid <= 1'b0;
      while (expected_members.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode_nd = m;
   endtask

   // one sequence of pushes with a shaped value mix, closed by a report
   task automatic push_sequence(input int unsigned n);
      value_style_type     style;
      logic [SAMPLE_W-1:0] drift;
      logic [SAMPLE_W-1:0] v;
      style = value_style_type'($urandom_range(0, 3));
      drift = $urandom;
      sender_steady = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < n; i++) begin
         case (style)
            STYLE_WIDE: begin
               v = $urandom;
            end
            STYLE_NARROW: begin
               v = SAMPLE_W'($urandom_range(0, 16)) - SAMPLE_W'(8);
            end
            STYLE_EDGE: begin
               case ($urandom_range(0, 4))
                  0: v = 32'h8000_0000;
                  1: v = 32'h7fff_ffff;
                  2: v = 32'hffff_ffff;
                  3: v = 32'h0000_0000;
                  default: v = 32'h0000_0001;
               endcase
            end
            default: begin
               drift = drift + SAMPLE_W'($urandom_range(0, 6)) - SAMPLE_W'(2);
               v = drift;
            end
         endcase
         if ($urandom_range(0, 9) == 0) begin
            v = $urandom;
         end
         send_beat(lis_pkg::OP_PUSH, v, 1'b0, NO_RESULT);
      end
      send_beat(lis_pkg::OP_REPORT, $urandom, 1'b0, NO_RESULT);
   endtask

   // result side stall: short random stalls, calm stretches, one long hold
   initial begin
      int unsigned hold_left;
      int unsigned stall_left;
      int unsigned calm_left;
      bit          hold_done;
      int unsigned r;
      hold_left  = 0;
      stall_left = 0;
      calm_left  = 0;
      hold_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_stall <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               calm_left = $urandom_range(0, 6);
               rsp_stall <= 1'b0;
            end else if (r < 90) begin
               stall_left = $urandom_range(0, 2);
               rsp_stall <= 1'b1;
            end else if (r < 98) begin
               calm_left = $urandom_range(20, 60);
               rsp_stall <= 1'b0;
            end else begin
               stall_left = $urandom_range(20, 60);
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   // compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      member_beat_type got;
      member_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = '{rsp_element_value, rsp_element_position, rsp_subsequence_length,
                 rsp_overflowed, rsp_last};
         results_seen++;
         if (expected_members.size() == 0) begin
            flag_mismatch($sformatf("result beat with nothing expected, value %0d",
                                    $signed(got.value)));
         end else begin
            want = expected_members.pop_front();
            if (got.value !== want.value) begin
               flag_mismatch($sformatf("element_value %0d, expected %0d",
                                       $signed(got.value), $signed(want.value)));
            end
            if (got.position !== want.position) begin
               flag_mismatch($sformatf("element_position %0d, expected %0d",
                                       got.position, want.position));
            end
            if (got.length !== want.length) begin
               flag_mismatch($sformatf("subsequence_length %0d, expected %0d",
                                       got.length, want.length));
            end
            if (got.overflowed !== want.overflowed) begin
               flag_mismatch($sformatf("overflowed %b, expected %b",
                                       got.overflowed, want.overflowed));
            end
            if (got.last !== want.last) begin
               flag_mismatch($sformatf("last %b, expected %b", got.last, want.last));
            end
         end
      end
   end

   // stimulus: reset, directed rows, then random phases per mode
   initial begin
      bit          phase_mode [3];
      int unsigned phase_end;
      int unsigned r;
      phase_mode = '{1'b1, 1'b0, 1'b1};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i]) begin
         case (SCRIPT[i].kind)
            ROW_MODE: begin
               set_mode(SCRIPT[i].value[0]);
            end
            ROW_PUSH: begin
               send_beat(lis_pkg::OP_PUSH, SCRIPT[i].value, 1'b0, NO_RESULT);
            end
            default: begin
               send_beat(lis_pkg::OP_REPORT, SCRIPT[i].value, SCRIPT[i].typed,
                         SCRIPT[i].want);
            end
         endcase
      end

      foreach (phase_mode[p]) begin
         set_mode(phase_mode[p]);
         phase_end = beats_sent + 100;
         // overrun past capacity, then the long hold on the result side
         if (p == 0) begin
            push_sequence(CAPACITY + 4);
            hold_asked <= 1'b1;
         end
         // exactly full, no overflow
         if (p == 1) begin
            push_sequence(CAPACITY);
         end
         while (beats_sent < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               push_sequence(0);
            end else if (r < 88) begin
               push_sequence($urandom_range(1, 12));
            end else begin
               push_sequence($urandom_range(13, 40));
            end
         end
      end

      // drain and let the block settle
      req_valid <= 1'b0;
      while (expected_members.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("** longest_increasing_subsequence: PASSED **");
      end else begin
         $display("** longest_increasing_subsequence: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
